// ===== design/cqi_pkg.sv =====
// Shared types, constants and pointer helpers for the circular queue with insert.
package cqi_pkg;

	localparam int DEPTH    = 8;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int VALUE_W  = 32;
	localparam int ACTION_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 3;
	localparam int CMP_W    = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

	typedef logic [PTR_W-1:0] ptr_t;

	localparam ptr_t FULL_N = PTR_W'(DEPTH - 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH,
		ACT_POP,
		ACT_PEEK,
		ACT_INSERT
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS_WR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               we;
		ptr_t               waddr;
		logic [VALUE_W-1:0] wdata;
		logic               re;
		ptr_t               raddr;
	} mem_req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} res_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		if (p == FULL_N) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		if (p == '0) begin
			return FULL_N;
		end
		return p - PTR_W'(1);
	endfunction

	// Number of stored values, (tail - head) mod DEPTH.
	function automatic ptr_t occupancy(input ptr_t tail, input ptr_t head);
		if (tail >= head) begin
			return tail - head;
		end
		return tail - head + PTR_W'(DEPTH);
	endfunction

	function automatic logic [COUNT_W-1:0] to_count(input ptr_t n);
		logic [CMP_W-1:0] w;
		w = CMP_W'(n);
		return w[COUNT_W-1:0];
	endfunction

endpackage

// ===== design/cqi_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
module cqi_mem import cqi_pkg::*; (
	input  logic               clk,
	input  mem_req_t           req,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/cqi_seq.sv =====
// Sequencer: head and tail pointers, action decode and the one-entry-per-step insert shift.
module cqi_seq import cqi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [VALUE_W-1:0] in_value,
	input  logic [POS_W-1:0]   position,
	output mem_req_t           mem_req,
	input  logic [VALUE_W-1:0] rdata,
	output logic               res_valid,
	input  logic               res_take,
	output res_t               res
);

	state_t             state_q, state_d;
	ptr_t               head_q, head_d;
	ptr_t               tail_q, tail_d;
	ptr_t               rp_q, rp_d;
	ptr_t               steps_q, steps_d;
	action_t            act_q, act_d;
	logic [VALUE_W-1:0] val_q, val_d;
	logic               res_ok_q, res_ok_d;
	logic [VALUE_W-1:0] res_val_q, res_val_d;

	ptr_t               n;
	logic [CMP_W-1:0]   k_w;
	logic [CMP_W-1:0]   n_w;
	logic [CMP_W-1:0]   span_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		rp_q      <= rp_d;
		steps_q   <= steps_d;
		act_q     <= act_d;
		val_q     <= val_d;
		res_ok_q  <= res_ok_d;
		res_val_q <= res_val_d;
	end

	always_comb begin
		n      = occupancy(tail_q, head_q);
		k_w    = CMP_W'(position);
		n_w    = CMP_W'(n);
		span_w = n_w + CMP_W'(1) - k_w;

		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		rp_d      = rp_q;
		steps_d   = steps_q;
		act_d     = act_q;
		val_d     = val_q;
		res_ok_d  = res_ok_q;
		res_val_d = res_val_q;

		mem_req       = '0;
		mem_req.waddr = ptr_inc(rp_q);
		mem_req.raddr = rp_q;
		in_ready      = (state_q == ST_IDLE);
		res_valid     = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_d     = action_t'(action);
					val_d     = in_value;
					res_ok_d  = 1'b0;
					res_val_d = '0;
					state_d   = ST_FIN;
					case (action_t'(action))
						ACT_PUSH: begin
							if (n != FULL_N) begin
								tail_d        = ptr_inc(tail_q);
								mem_req.we    = 1'b1;
								mem_req.waddr = ptr_inc(tail_q);
								mem_req.wdata = in_value;
								res_ok_d      = 1'b1;
							end
						end
						ACT_POP, ACT_PEEK: begin
							if (n != '0) begin
								mem_req.re    = 1'b1;
								mem_req.raddr = ptr_inc(head_q);
								state_d       = ST_READ;
							end
						end
						ACT_INSERT: begin
							if (n != FULL_N && k_w >= CMP_W'(1) && k_w <= n_w + CMP_W'(1)) begin
								rp_d    = tail_q;
								steps_d = span_w[PTR_W-1:0];
								state_d = (span_w == '0) ? ST_INS_WR : ST_SH_RD;
							end
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_READ: begin
				res_ok_d  = 1'b1;
				res_val_d = rdata;
				if (act_q == ACT_POP) begin
					head_d = ptr_inc(head_q);
				end
				state_d = ST_FIN;
			end
			ST_SH_RD: begin
				mem_req.re = 1'b1;
				state_d    = ST_SH_WR;
			end
			ST_SH_WR: begin
				// move the entry one slot toward the tail, then step back
				mem_req.we    = 1'b1;
				mem_req.wdata = rdata;
				rp_d          = ptr_dec(rp_q);
				steps_d       = steps_q - PTR_W'(1);
				state_d       = (steps_q == PTR_W'(1)) ? ST_INS_WR : ST_SH_RD;
			end
			ST_INS_WR: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = val_q;
				tail_d        = ptr_inc(tail_q);
				res_ok_d      = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.ok    = res_ok_q;
	assign res.value = res_val_q;
	assign res.count = to_count(n);

endmodule

// ===== design/circular_queue_with_insert.sv =====
// Top level of the circular queue with positional insert.
//
// A ring buffer of DEPTH slots holding at most DEPTH-1 signed 32-bit values. Each input
// transfer carries one action (push, pop, peek at the head, insert at a one-based position)
// and produces exactly one result transfer with an ok flag, the value popped or peeked
// (zero otherwise) and the count after the action. The block works on one item at a time:
// in_ready is high only while the sequencer is idle. A push or a failed action goes from
// idle straight to the finish state; a pop or peek passes through a read state first (the
// slot memory has a registered read port); an insert at position k with n values stored
// shifts n+1-k entries, each read and rewritten one slot toward the tail through the
// single memory port pair. A successful insert needs n <= DEPTH-2, so the longest one is
// at the head of a queue one short of full. The result sits in an output register, so the
// sequencer goes back to idle as soon as that register is free; if out_ready is held low,
// the sequencer waits with its finished result until it can hand it over. The slot memory
// is not cleared at reset; only occupied slots are ever read.
module circular_queue_with_insert import cqi_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [VALUE_W-1:0]  in_value,
	input  logic [POS_W-1:0]           position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       ok,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [COUNT_W-1:0]         count
);

	mem_req_t           mem_req;
	logic [VALUE_W-1:0] rdata;
	logic               res_valid;
	logic               res_take;
	res_t               res;

	logic               out_valid_q;
	logic               ok_q;
	logic [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0] count_q;

	cqi_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.in_value  (in_value),
		.position  (position),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	cqi_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Load the output register when it is empty or its result transfers this cycle.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the result transfers.
	always_ff @(posedge clk) begin
		if (res_take) begin
			ok_q    <= res.ok;
			value_q <= res.value;
			count_q <= res.count;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign out_value = value_q;
	assign count     = count_q;

endmodule
